// ===== rtl/single_wire_humidity_sensor_reader_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the single-wire humidity sensor reader
// Shared property forms used by the reader's checker.
// ----------------------------------------------------------------------------
`ifndef SINGLE_WIRE_HUMIDITY_SENSOR_READER_ASSERT_SVH
`define SINGLE_WIRE_HUMIDITY_SENSOR_READER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define SWHSR_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SWHSR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/swhsr_pkg.sv =====
// ----------------------------------------------------------------------------
// Single-wire humidity sensor reader package
// Types, register indexes, codes and constants shared by the reader.
// ----------------------------------------------------------------------------
`default_nettype none

package swhsr_pkg;

   localparam int PULSE_COUNT_WIDTH = 16;
   localparam int CMP_WIDTH = (PULSE_COUNT_WIDTH > 16) ? PULSE_COUNT_WIDTH : 16;
   localparam int PHASE_TICKS_WIDTH = 16;
   localparam int BIT_INDEX_WIDTH = 6;
   localparam int FRAME_WIDTH = 40;
   localparam int SINCE_WIDTH = 24;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH = 24;

   localparam logic [BIT_INDEX_WIDTH-1:0] NUM_BITS = BIT_INDEX_WIDTH'(40);

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_START_LOW    = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RELEASE_WAIT = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TIMEOUT      = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MIN_INTERVAL = 2'd3;

   localparam logic [15:0] START_LOW_RESET    = 16'd1100;
   localparam logic [7:0]  RELEASE_WAIT_RESET = 8'd55;
   localparam logic [15:0] TIMEOUT_RESET      = 16'd1000;
   localparam logic [23:0] MIN_INTERVAL_RESET = 24'd2000000;

   localparam logic [1:0] FAIL_NONE     = 2'd0;
   localparam logic [1:0] FAIL_TIMEOUT  = 2'd1;
   localparam logic [1:0] FAIL_CHECKSUM = 2'd2;

   typedef enum logic [6:0] {
      PH_IDLE      = 7'b0000001,
      PH_START     = 7'b0000010,
      PH_RELEASE   = 7'b0000100,
      PH_RESP_LOW  = 7'b0001000,
      PH_RESP_HIGH = 7'b0010000,
      PH_BIT_LOW   = 7'b0100000,
      PH_BIT_HIGH  = 7'b1000000
   } phase_type;

   typedef struct packed {
      logic pin_level;
      logic start_read;
      logic force_read;
   } req_type;

   typedef struct packed {
      logic               drive_line_low;
      logic               busy_res;
      logic               done_res;
      logic               read_ok;
      logic               from_cache;
      logic [1:0]         failure_code;
      logic [15:0]        humidity_tenths;
      logic signed [15:0] temperature_tenths;
   } rsp_type;

   typedef struct packed {
      logic [15:0] start_low_ticks;
      logic [7:0]  release_wait_ticks;
      logic [15:0] timeout_ticks;
      logic [23:0] min_interval_ticks;
   } cfg_type;

   typedef struct packed {
      logic advance;
      logic fire;
   } pipe_ctl_type;

endpackage

`default_nettype wire

// ===== rtl/swhsr_csr.sv =====
// ----------------------------------------------------------------------------
// Reader configuration registers
// Holds the start, release, timeout and interval settings.
// ----------------------------------------------------------------------------
`default_nettype none

module swhsr_csr
   import swhsr_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata,
   output cfg_type                    cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_START_LOW:    cfg_in.start_low_ticks    = csr_wdata[15:0];
            CSR_RELEASE_WAIT: cfg_in.release_wait_ticks = csr_wdata[7:0];
            CSR_TIMEOUT:      cfg_in.timeout_ticks      = csr_wdata[15:0];
            CSR_MIN_INTERVAL: cfg_in.min_interval_ticks = csr_wdata[23:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_low_ticks    <= START_LOW_RESET;
         cfg_ff.release_wait_ticks <= RELEASE_WAIT_RESET;
         cfg_ff.timeout_ticks      <= TIMEOUT_RESET;
         cfg_ff.min_interval_ticks <= MIN_INTERVAL_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/swhsr_in_stage.sv =====
// ----------------------------------------------------------------------------
// Reader input register
// Captures one sample transaction and holds it until the step logic takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module swhsr_in_stage
   import swhsr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_type      req_data,
   input  pipe_ctl_type ctl,
   output logic         item_valid,
   output req_type      item
);

   logic    item_valid_ff;
   req_type item_ff;

   assign req_stall = item_valid_ff && !ctl.advance;
   assign item_valid = item_valid_ff;
   assign item = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         item_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         item_ff <= req_data;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/swhsr_step.sv =====
// ----------------------------------------------------------------------------
// Reader sample step
// Sequencer state and the per-sample logic that times pulses and builds a frame.
// ----------------------------------------------------------------------------
`default_nettype none

module swhsr_step
   import swhsr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  pipe_ctl_type ctl,
   input  req_type      item,
   output rsp_type      result
);

   phase_type                    phase_ff, phase_in;
   logic [PHASE_TICKS_WIDTH-1:0] phase_ticks_ff, phase_ticks_in;
   logic [PULSE_COUNT_WIDTH-1:0] pulse_count_ff, pulse_count_in;
   logic [PULSE_COUNT_WIDTH-1:0] low_width_ff, low_width_in;
   logic [BIT_INDEX_WIDTH-1:0]   bit_index_ff, bit_index_in;
   logic [FRAME_WIDTH-1:0]       frame_bits_ff, frame_bits_in;
   logic [SINCE_WIDTH-1:0]       since_last_read_ff, since_last_read_in;
   logic                         last_ok_ff, last_ok_in;

   always_comb begin
      logic [SINCE_WIDTH-1:0]       since_inc;
      logic [PHASE_TICKS_WIDTH-1:0] ticks_next;
      logic                         drive;
      logic                         done;
      logic                         ok;
      logic                         cached;
      logic [1:0]                   fail;
      logic                         pulse_run;
      logic                         level;
      logic                         timeout;
      logic                         resample;
      logic [7:0]                   sum;
      logic                         good;
      logic [14:0]                  mag;

      phase_in           = phase_ff;
      phase_ticks_in     = phase_ticks_ff;
      pulse_count_in     = pulse_count_ff;
      low_width_in       = low_width_ff;
      bit_index_in       = bit_index_ff;
      frame_bits_in      = frame_bits_ff;
      last_ok_in         = last_ok_ff;
      drive              = 1'b0;
      done               = 1'b0;
      ok                 = 1'b0;
      cached             = 1'b0;
      fail               = FAIL_NONE;
      pulse_run          = 1'b0;
      level              = 1'b0;
      timeout            = 1'b0;
      resample           = 1'b0;
      sum                = 8'd0;
      good               = 1'b0;
      ticks_next         = '0;

      since_inc = (since_last_read_ff == '1) ? since_last_read_ff
                                             : since_last_read_ff + SINCE_WIDTH'(1);
      since_last_read_in = since_inc;

      if (phase_ff == PH_IDLE && item.start_read) begin
         if (!item.force_read && since_inc < cfg.min_interval_ticks) begin
            done   = 1'b1;
            cached = 1'b1;
            ok     = last_ok_ff;
         end else begin
            since_last_read_in = '0;
            frame_bits_in      = '0;
            bit_index_in       = '0;
            phase_in           = PH_START;
            phase_ticks_in     = '0;
         end
      end

      unique case (phase_in)
         PH_IDLE: begin
         end
         PH_START: begin
            drive          = 1'b1;
            ticks_next     = phase_ticks_in + PHASE_TICKS_WIDTH'(1);
            phase_ticks_in = ticks_next;
            if (ticks_next >= cfg.start_low_ticks) begin
               phase_in       = PH_RELEASE;
               phase_ticks_in = '0;
            end
         end
         PH_RELEASE: begin
            if (phase_ticks_in >= PHASE_TICKS_WIDTH'(cfg.release_wait_ticks)) begin
               phase_in       = PH_RESP_LOW;
               pulse_count_in = '0;
               pulse_run      = 1'b1;
            end else begin
               phase_ticks_in = phase_ticks_in + PHASE_TICKS_WIDTH'(1);
            end
         end
         PH_RESP_LOW, PH_RESP_HIGH, PH_BIT_LOW, PH_BIT_HIGH: begin
            pulse_run = 1'b1;
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase

      if (pulse_run) begin
         level = (phase_in == PH_RESP_HIGH) || (phase_in == PH_BIT_HIGH);
         if (item.pin_level == level) begin
            if (CMP_WIDTH'(pulse_count_in) >= CMP_WIDTH'(cfg.timeout_ticks)
                  || pulse_count_in == '1) begin
               timeout = 1'b1;
            end else begin
               pulse_count_in = pulse_count_in + PULSE_COUNT_WIDTH'(1);
            end
         end else begin
            resample = 1'b1;
            unique case (phase_in)
               PH_RESP_LOW: begin
                  phase_in = PH_RESP_HIGH;
               end
               PH_RESP_HIGH: begin
                  phase_in = PH_BIT_LOW;
               end
               PH_BIT_LOW: begin
                  low_width_in = pulse_count_in;
                  phase_in     = PH_BIT_HIGH;
               end
               PH_BIT_HIGH: begin
                  frame_bits_in = {frame_bits_in[FRAME_WIDTH-2:0],
                                   pulse_count_in > low_width_in};
                  bit_index_in  = bit_index_in + BIT_INDEX_WIDTH'(1);
                  if (bit_index_in >= NUM_BITS) begin
                     sum = frame_bits_in[39:32] + frame_bits_in[31:24]
                         + frame_bits_in[23:16] + frame_bits_in[15:8];
                     good       = (frame_bits_in[7:0] == sum);
                     phase_in   = PH_IDLE;
                     last_ok_in = good;
                     done       = 1'b1;
                     ok         = good;
                     fail       = good ? FAIL_NONE : FAIL_CHECKSUM;
                     resample   = 1'b0;
                  end else begin
                     phase_in = PH_BIT_LOW;
                  end
               end
               default: begin
                  resample = 1'b0;
               end
            endcase
            if (resample) begin
               if (cfg.timeout_ticks == '0) begin
                  timeout = 1'b1;
               end else begin
                  pulse_count_in = PULSE_COUNT_WIDTH'(1);
               end
            end
         end
         if (timeout) begin
            phase_in   = PH_IDLE;
            last_ok_in = 1'b0;
            done       = 1'b1;
            ok         = 1'b0;
            fail       = FAIL_TIMEOUT;
         end
      end

      mag = {frame_bits_in[22:16], frame_bits_in[15:8]};

      result.drive_line_low     = drive;
      result.busy_res           = (phase_in != PH_IDLE);
      result.done_res           = done;
      result.read_ok            = ok;
      result.from_cache         = cached;
      result.failure_code       = fail;
      result.humidity_tenths    = '0;
      result.temperature_tenths = '0;
      if (done && ok) begin
         result.humidity_tenths    = frame_bits_in[39:24];
         result.temperature_tenths = frame_bits_in[23] ? -$signed({1'b0, mag})
                                                       : $signed({1'b0, mag});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff           <= PH_IDLE;
         phase_ticks_ff     <= '0;
         pulse_count_ff     <= '0;
         low_width_ff       <= '0;
         bit_index_ff       <= '0;
         frame_bits_ff      <= '0;
         since_last_read_ff <= '1;
         last_ok_ff         <= 1'b0;
      end else if (ctl.fire) begin
         phase_ff           <= phase_in;
         phase_ticks_ff     <= phase_ticks_in;
         pulse_count_ff     <= pulse_count_in;
         low_width_ff       <= low_width_in;
         bit_index_ff       <= bit_index_in;
         frame_bits_ff      <= frame_bits_in;
         since_last_read_ff <= since_last_read_in;
         last_ok_ff         <= last_ok_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/swhsr_out_stage.sv =====
// ----------------------------------------------------------------------------
// Reader result register
// Holds one result transaction and decides when the pipeline may advance.
// ----------------------------------------------------------------------------
`default_nettype none

module swhsr_out_stage
   import swhsr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         item_valid,
   input  rsp_type      result,
   output pipe_ctl_type ctl,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_type      rsp_data
);

   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;

   assign ctl.advance = !rsp_valid_ff || !rsp_stall;
   assign ctl.fire = item_valid && ctl.advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.advance) begin
         rsp_valid_ff <= item_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.fire) begin
         rsp_data_ff <= result;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/single_wire_humidity_sensor_reader.sv =====
// The reader takes one sample transaction per clock cycle, limited only by rsp_stall.
// The path is the input register, one pass of the step logic, then the result register.
// Reset is synchronous and active high; it clears the sequencer to idle, loads the
// default settings and saturates the interval counter so the first read runs.
// ----------------------------------------------------------------------------
// Single-wire humidity sensor reader
// Drives the start pulse, times the sensor's response and decodes the frame.
// ----------------------------------------------------------------------------
`default_nettype none

module single_wire_humidity_sensor_reader
   import swhsr_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  req_type                    req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output rsp_type                    rsp_data,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   cfg_type      cfg;
   pipe_ctl_type ctl;
   logic         item_valid;
   req_type      item;
   rsp_type      result;

   swhsr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   swhsr_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .ctl        (ctl),
      .item_valid (item_valid),
      .item       (item)
   );

   swhsr_step u_step (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .ctl    (ctl),
      .item   (item),
      .result (result)
   );

   swhsr_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .result     (result),
      .ctl        (ctl),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire

// ===== rtl/swhsr_checker.sv =====
// ----------------------------------------------------------------------------
// Reader port checker
// Checks the consistency of result transactions seen on the top-level ports.
// ----------------------------------------------------------------------------
`default_nettype none

`include "single_wire_humidity_sensor_reader_assert.svh"

module swhsr_checker
   import swhsr_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   `SWHSR_ASSERT_IMP(a_done_not_busy, clock, reset, rsp_valid && rsp_data.done_res, !rsp_data.busy_res, "done result still busy")
   `SWHSR_ASSERT_IMP(a_cache_clean, clock, reset, rsp_valid && rsp_data.from_cache, rsp_data.done_res && !rsp_data.drive_line_low && rsp_data.failure_code == FAIL_NONE, "bad cached result")
   `SWHSR_ASSERT_IMP(a_fail_not_ok, clock, reset, rsp_valid && rsp_data.failure_code != FAIL_NONE, rsp_data.done_res && !rsp_data.read_ok, "failure without done")
   `SWHSR_ASSERT_IMP(a_values_zero, clock, reset, rsp_valid && !rsp_data.read_ok, rsp_data.humidity_tenths == '0 && rsp_data.temperature_tenths == '0, "values without good read")
   `SWHSR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "stalled result changed")

endmodule

bind single_wire_humidity_sensor_reader swhsr_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire

// ===== tb/sv/tb_single_wire_humidity_sensor_reader.sv =====
// ----------------------------------------------------------------------------
// Testbench for the single-wire humidity sensor reader
// Sends line samples and read requests, one transaction per tick, and changes
// the timing settings between phases. A cycle-level model of the read sequence
// predicts the result of every sample, and each result transaction is checked
// field by field. Both channels idle at random, with one calm stretch.
// ----------------------------------------------------------------------------
module tb_single_wire_humidity_sensor_reader;
   import swhsr_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 1500000;
   localparam int RANDOM_SAMPLES = 1550;
   localparam int PHASE_SAMPLES = 180;

   class humidity_read_scoreboard;
      logic [15:0] start_low;
      logic [7:0] release_wait;
      logic [15:0] timeout;
      logic [23:0] read_spacing;
      phase_type phase;
      logic [PHASE_TICKS_WIDTH-1:0] phase_ticks;
      logic [PULSE_COUNT_WIDTH-1:0] pulse_count;
      logic [PULSE_COUNT_WIDTH-1:0] low_width;
      logic [BIT_INDEX_WIDTH-1:0] bit_index;
      logic [FRAME_WIDTH-1:0] frame;
      logic [SINCE_WIDTH-1:0] since_last;
      logic last_ok;
      rsp_type pending_readings[$];
      int errors;

      function void clear();
         start_low = START_LOW_RESET;
         release_wait = RELEASE_WAIT_RESET;
         timeout = TIMEOUT_RESET;
         read_spacing = MIN_INTERVAL_RESET;
         phase = PH_IDLE;
         phase_ticks = '0;
         pulse_count = '0;
         low_width = '0;
         bit_index = '0;
         frame = '0;
         since_last = '1;
         last_ok = 1'b0;
         pending_readings.delete();
         errors = 0;
      endfunction

      function void set_register(logic [CSR_INDEX_WIDTH-1:0] idx,
                                 logic [CSR_DATA_WIDTH-1:0] val);
         case (idx)
            CSR_START_LOW: start_low = val[15:0];
            CSR_RELEASE_WAIT: release_wait = val[7:0];
            CSR_TIMEOUT: timeout = val[15:0];
            CSR_MIN_INTERVAL: read_spacing = val[23:0];
         endcase
      endfunction

      function rsp_type sample_tick(req_type s);
         rsp_type r;
         logic again;
         logic hi;
         logic good;
         logic [7:0] sum;
         logic [15:0] mag;
         r = '0;
         if (since_last != '1) since_last++;
         if (phase == PH_IDLE && s.start_read) begin
            if (!s.force_read && since_last < read_spacing) begin
               r.done_res = 1'b1;
               r.from_cache = 1'b1;
               r.read_ok = last_ok;
            end else begin
               since_last = '0;
               frame = '0;
               bit_index = '0;
               phase = PH_START;
               phase_ticks = '0;
            end
         end
         again = 1'b1;
         while (again) begin
            again = 1'b0;
            case (phase)
               PH_IDLE: ;
               PH_START: begin
                  r.drive_line_low = 1'b1;
                  phase_ticks++;
                  if (phase_ticks >= start_low) begin
                     phase = PH_RELEASE;
                     phase_ticks = '0;
                  end
               end
               PH_RELEASE: begin
                  if (phase_ticks >= release_wait) begin
                     phase = PH_RESP_LOW;
                     pulse_count = '0;
                     again = 1'b1;
                  end else begin
                     phase_ticks++;
                  end
               end
               default: begin
                  hi = (phase == PH_RESP_HIGH || phase == PH_BIT_HIGH);
                  if (s.pin_level == hi) begin
                     if (pulse_count >= timeout || pulse_count == '1) begin
                        phase = PH_IDLE;
                        last_ok = 1'b0;
                        r.done_res = 1'b1;
                        r.read_ok = 1'b0;
                        r.failure_code = FAIL_TIMEOUT;
                     end else begin
                        pulse_count++;
                     end
                  end else begin
                     case (phase)
                        PH_RESP_LOW: phase = PH_RESP_HIGH;
                        PH_RESP_HIGH: phase = PH_BIT_LOW;
                        PH_BIT_LOW: begin
                           low_width = pulse_count;
                           phase = PH_BIT_HIGH;
                        end
                        default: begin
                           frame = {frame[FRAME_WIDTH-2:0], pulse_count > low_width};
                           bit_index++;
                           if (bit_index >= NUM_BITS) begin
                              sum = frame[39:32] + frame[31:24] + frame[23:16] + frame[15:8];
                              good = (frame[7:0] == sum);
                              phase = PH_IDLE;
                              last_ok = good;
                              r.done_res = 1'b1;
                              r.read_ok = good;
                              r.failure_code = good ? FAIL_NONE : FAIL_CHECKSUM;
                           end else begin
                              phase = PH_BIT_LOW;
                           end
                        end
                     endcase
                     if (phase != PH_IDLE) begin
                        pulse_count = '0;
                        again = 1'b1;
                     end
                  end
               end
            endcase
         end
         r.busy_res = (phase != PH_IDLE);
         if (r.done_res && r.read_ok) begin
            mag = {1'b0, frame[22:8]};
            r.humidity_tenths = frame[39:24];
            r.temperature_tenths = frame[23] ? (16'd0 - mag) : mag;
         end
         return r;
      endfunction

      function void note_sample(req_type s);
         pending_readings.push_back(sample_tick(s));
      endfunction

      function void compare_field(string field, logic [15:0] want, logic [15:0] got);
         if (got !== want) begin
            $display("%0t: %s expected %0h, actual %0h", $time, field, want, got);
            errors++;
         end
      endfunction

      function void check_reading(rsp_type got);
         rsp_type want;
         if (pending_readings.size() == 0) begin
            $display("%0t: result transaction expected none, actual %h", $time, got);
            errors++;
            return;
         end
         want = pending_readings.pop_front();
         compare_field("drive_line_low", 16'(want.drive_line_low), 16'(got.drive_line_low));
         compare_field("busy_res", 16'(want.busy_res), 16'(got.busy_res));
         compare_field("done_res", 16'(want.done_res), 16'(got.done_res));
         compare_field("read_ok", 16'(want.read_ok), 16'(got.read_ok));
         compare_field("from_cache", 16'(want.from_cache), 16'(got.from_cache));
         compare_field("failure_code", 16'(want.failure_code), 16'(got.failure_code));
         compare_field("humidity_tenths", want.humidity_tenths, got.humidity_tenths);
         compare_field("temperature_tenths", want.temperature_tenths, got.temperature_tenths);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = CSR_START_LOW;
   logic [CSR_DATA_WIDTH-1:0] csr_wdata = '0;
   bit calm = 1'b0;
   int sent = 0;
   int unsigned cycles = 0;
   humidity_read_scoreboard board;

   single_wire_humidity_sensor_reader DUT (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= !calm && ($urandom_range(99) < 21);
   end

   always @(negedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_reading(rsp_data);
   end

   function automatic logic chatter();
      return ($urandom_range(19) == 0);
   endfunction

   task automatic put_sample(input logic pin, input logic ask, input logic force_it);
      req_type item;
      item.pin_level = pin;
      item.start_read = ask;
      item.force_read = force_it;
      while (!calm && $urandom_range(99) < 21) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(negedge clock);
      while (req_stall) @(negedge clock);
      @(posedge clock);
      board.note_sample(item);
      sent++;
   endtask

   task automatic emit_pulse(input logic lvl, input int width);
      repeat (width) put_sample(lvl, chatter(), 1'($urandom_range(1)));
   endtask

   task automatic ride_out_start();
      while (board.phase == PH_START ||
             (board.phase == PH_RELEASE && board.phase_ticks < board.release_wait))
         put_sample(1'($urandom_range(1)), chatter(), 1'($urandom_range(1)));
   endtask

   task automatic settle_block();
      logic lvl = 1'b0;
      while (board.phase != PH_IDLE) begin
         put_sample(lvl, 1'b0, 1'b0);
         lvl = ~lvl;
      end
   endtask

   task automatic write_csr(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [CSR_DATA_WIDTH-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      while (!csr_ready) @(negedge clock);
      @(posedge clock);
      board.set_register(idx, val);
   endtask

   task automatic program_settings(input logic [15:0] low_ticks, input logic [7:0] wait_ticks,
                                   input logic [15:0] limit_ticks, input logic [23:0] interval);
      req_valid <= 1'b0;
      while (board.pending_readings.size() != 0) @(posedge clock);
      write_csr(CSR_START_LOW, 24'(low_ticks));
      write_csr(CSR_RELEASE_WAIT, 24'(wait_ticks));
      write_csr(CSR_TIMEOUT, 24'(limit_ticks));
      write_csr(CSR_MIN_INTERVAL, interval);
      csr_valid <= 1'b0;
   endtask

   task automatic run_read_sequence();
      int cap;
      int abort_at;
      int lw;
      int hw;
      int width;
      logic [31:0] data;
      logic [7:0] csum;
      logic [39:0] bits;
      cap = (board.timeout < 6) ? board.timeout : 6;
      data = (cap < 2) ? 32'd0 : $urandom;
      csum = data[31:24] + data[23:16] + data[15:8] + data[7:0];
      if (cap >= 2 && $urandom_range(4) == 0) csum ^= 8'(1 << $urandom_range(7));
      bits = {data, csum};
      abort_at = (board.timeout <= 8 && $urandom_range(5) == 0) ? $urandom_range(81) : -1;
      put_sample(1'b1, 1'b1, 1'($urandom_range(1)));
      if (board.phase == PH_IDLE) put_sample(1'b1, 1'b1, 1'b1);
      ride_out_start();
      for (int k = 0; k < 82 && board.phase != PH_IDLE; k++) begin
         if (k < 2) begin
            width = (k == 0 && $urandom_range(7) == 0) ? 0 : $urandom_range(cap, 1);
         end else if (!k[0]) begin
            if (bits[39 - (k - 2) / 2]) begin
               lw = $urandom_range(cap - 1, 1);
               hw = $urandom_range(cap, lw + 1);
            end else begin
               lw = $urandom_range(cap, 1);
               hw = $urandom_range(lw, 1);
            end
            width = lw;
         end else begin
            width = hw;
         end
         if (k == abort_at) width = board.timeout + 1;
         emit_pulse(k[0], width);
      end
      if (board.phase != PH_IDLE) put_sample(1'b0, 1'b0, 1'b0);
      repeat ($urandom_range(4)) put_sample(1'b1, chatter(), 1'($urandom_range(1)));
   endtask

   task automatic run_noise();
      repeat ($urandom_range(30, 5))
         put_sample(1'($urandom_range(1)), $urandom_range(3) == 0, 1'($urandom_range(1)));
      settle_block();
   endtask

   initial begin
      int phase_no;
      int stop_at;
      int target;
      logic [15:0] low_ticks;
      logic [7:0] wait_ticks;
      logic [15:0] limit_ticks;
      logic [23:0] interval;
      board = new();
      board.clear();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      program_settings(16'd2, 8'd1, 16'd6, 24'd300);

      // The first request after reset finds the interval counter saturated.
      put_sample(1'b0, 1'b0, 1'b0);
      put_sample(1'b1, 1'b0, 1'b1);
      put_sample(1'b1, 1'b1, 1'b0);
      put_sample(1'b0, 1'b0, 1'b0);
      put_sample(1'b1, 1'b0, 1'b0);
      put_sample(1'b1, 1'b0, 1'b0);
      put_sample(1'b1, 1'b1, 1'b1);
      repeat (4) put_sample(1'b1, 1'b0, 1'b0);
      put_sample(1'b1, 1'b0, 1'b0);
      put_sample(1'b1, 1'b1, 1'b0);
      put_sample(1'b0, 1'b1, 1'b1);
      put_sample(1'b1, 1'b0, 1'b0);
      put_sample(1'b0, 1'b0, 1'b0);
      repeat (7) put_sample(1'b0, 1'b0, 1'b0);

      target = sent + RANDOM_SAMPLES;
      phase_no = 0;
      while (sent < target) begin
         settle_block();
         low_ticks = 16'($urandom_range(4, 1));
         wait_ticks = 8'($urandom_range(3));
         limit_ticks = ($urandom_range(3) == 0) ? 16'hFFFF : 16'($urandom_range(8, 2));
         case ($urandom_range(2))
            0: interval = '0;
            1: interval = 24'($urandom_range(300, 20));
            default: interval = '1;
         endcase
         case (phase_no)
            0: begin
               low_ticks = 16'd1;
               wait_ticks = '0;
               limit_ticks = 16'd1;
               interval = '0;
            end
            1: begin
               low_ticks = 16'd3;
               wait_ticks = 8'd2;
               limit_ticks = 16'd6;
               interval = '1;
            end
            2: begin
               wait_ticks = '1;
               limit_ticks = '1;
            end
            default: ;
         endcase
         program_settings(low_ticks, wait_ticks, limit_ticks, interval);
         calm = (phase_no == 3);
         stop_at = sent + PHASE_SAMPLES;
         while (sent < stop_at) begin
            if ($urandom_range(9) < 7) run_read_sequence();
            else run_noise();
         end
         phase_no++;
      end

      // A low level held past a long timeout so that the read aborts, then a
      // request inside the interval that is answered from the held result.
      calm = 1'b0;
      settle_block();
      program_settings(16'd3, 8'd2, 16'd40, '1);
      put_sample(1'b1, 1'b1, 1'b1);
      ride_out_start();
      emit_pulse(1'b0, 41);
      put_sample(1'b1, 1'b1, 1'b0);

      req_valid <= 1'b0;
      while (board.pending_readings.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (board.errors == 0)
         $display("single_wire_humidity_sensor_reader regression: pass");
      else
         $display("single_wire_humidity_sensor_reader regression: fail");
      $finish;
   end

   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("single_wire_humidity_sensor_reader regression: fail");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/swhsr_pkg.sv
rtl/swhsr_csr.sv
rtl/swhsr_in_stage.sv
rtl/swhsr_step.sv
rtl/swhsr_out_stage.sv
rtl/single_wire_humidity_sensor_reader.sv
rtl/swhsr_checker.sv
tb/sv/tb_single_wire_humidity_sensor_reader.sv
